>>> hdl/wlhc_pkg.sv
package wlhc_pkg;

  // Default sample width
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // APB register map
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [1:0] REG_WIN_LO = 2'd0;
  localparam logic [1:0] REG_WIN_HI = 2'd1;
  localparam logic [1:0] REG_SAT_LO = 2'd2;
  localparam logic [1:0] REG_SAT_HI = 2'd3;

  localparam logic [15:0] WIN_LO_RST = 16'd0;
  localparam logic [15:0] WIN_HI_RST = 16'hFFFF;
  localparam logic [15:0] SAT_LO_RST = 16'd0;
  localparam logic [15:0] SAT_HI_RST = 16'd256;

  // Mask codes
  localparam logic [7:0] MASK_HSV   = 8'd0;
  localparam logic [7:0] MASK_BLUE  = 8'd1;
  localparam logic [7:0] MASK_GREEN = 8'd2;
  localparam logic [7:0] MASK_RED   = 8'd3;

  // Pipelined divider geometry: quotient always fits 8 bits
  localparam int unsigned DIV_NUM_W  = 24;
  localparam int unsigned DIV_DEN_W  = 16;
  localparam int unsigned DIV_QUO_W  = 8;
  localparam int unsigned DIV_STAGES = DIV_QUO_W;

  // Reciprocals for the constant divisions of the HSV conversion
  localparam logic [15:0] RECIP_510      = 16'd32896;  // floor(2^24 / 510)
  localparam int unsigned RECIP_510_SH   = 24;
  localparam logic [15:0] RECIP_30600    = 16'd35089;  // floor(2^30 / 30600)
  localparam int unsigned RECIP_30600_SH = 30;

  typedef struct packed {
    logic [7:0]         mask;
    logic [2:0]         sec;
    logic [5:0]         frac;
    logic signed [15:0] sat;
  } side_t;

  typedef struct packed {
    logic       lvl_use;
    logic [7:0] lvl;
    logic       sat_use;
    logic [7:0] satv;
  } fix_t;

endpackage

>>> hdl/wlhc_isqrt.sv
module wlhc_isqrt import wlhc_pkg::*; #(
  parameter int unsigned N = SAMPLE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*N-1:0] rad_i,
  output logic [N-1:0]   root_o
);

  // one root bit per stage, digit-by-digit method
  logic [2*N-1:0] rad_q  [N];
  logic [N+1:0]   rem_q  [N];
  logic [N-1:0]   root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [2*N-1:0] rad_in;
    logic [N+1:0]   rem_in;
    logic [N-1:0]   root_in;
    logic [N+3:0]   rem_sh;
    logic [N+3:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[2*N-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[2*N-3:0], 2'b00};
        rem_q[k]  <= ge ? (N+2)'(rem_sh - trial) : rem_sh[N+1:0];
        root_q[k] <= {root_in[N-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

>>> hdl/wlhc_div.sv
module wlhc_div import wlhc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_QUO_W-1:0] quo_o
);

  // restoring division, one quotient bit per stage; needs num < den * 2^DIV_QUO_W
  localparam int unsigned SH_W = DIV_NUM_W + DIV_QUO_W;

  logic [DIV_NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int unsigned SH = DIV_STAGES - 1 - k;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_QUO_W-1:0] quo_in;
    logic [SH_W-1:0]      dsh;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign dsh = SH_W'(den_in) << SH;
    assign ge  = (SH_W'(rem_in) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - dsh[DIV_NUM_W-1:0]) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[DIV_QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

>>> hdl/window_level_hsv_colorizer.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// freezes only while the output register holds an item not yet taken.
// The root takes one stage per result bit; the two dividers take eight each.
// Reset (rst_ni low, async) empties the pipeline and loads register defaults.
module window_level_hsv_colorizer import wlhc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  logic [7:0]                    mask_code_i,
  input  logic [8:0]                    hue_angle_i,
  input  logic signed [15:0]            sat_in_i,
  // color out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int unsigned N   = SAMPLE_BITS;
  localparam int unsigned LAT = N + 15;
  localparam int unsigned MW  = (N > 16) ? N : 16;

  // Stage map (register index):
  //   0         abs + squares, hue normalize
  //   1         sum of squares
  //   2..N+1    integer square root
  //   N+2..N+9  level and saturation dividers
  //   N+10      hold / sat select
  //   N+11      products v*(255-s), s*f, s*(60-f)
  //   N+12      numerators of p, q, t
  //   N+13      reciprocal estimates
  //   N+14      correction, channel select -> output register

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [15:0]        win_lo_q, win_hi_q;
  logic signed [15:0] sat_lo_q, sat_hi_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= WIN_LO_RST;
      win_hi_q <= WIN_HI_RST;
      sat_lo_q <= SAT_LO_RST;
      sat_hi_q <= SAT_HI_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIN_LO: win_lo_q <= pwdata[15:0];
        REG_WIN_HI: win_hi_q <= pwdata[15:0];
        REG_SAT_LO: sat_lo_q <= pwdata[15:0];
        REG_SAT_HI: sat_hi_q <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_WIN_LO: prdata[15:0] = win_lo_q;
      REG_WIN_HI: prdata[15:0] = win_hi_q;
      REG_SAT_LO: prdata[15:0] = sat_lo_q;
      REG_SAT_HI: prdata[15:0] = sat_hi_q;
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: single enable, valid bits ride along with the data
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: abs/squares, hue normalize + flip, sector split
  // --------------------------------------------------------------------------
  logic [N-1:0]   abs_re, abs_im;
  logic [9:0]     hue0, hue1;
  logic [2:0]     sec;
  logic [9:0]     frac_w;
  side_t          side_in;
  logic [2*N-1:0] sq_re_q, sq_im_q;
  side_t          side_q [LAT-1];

  assign abs_re = sample_real_i[N-1] ? N'(-sample_real_i) : N'(sample_real_i);
  assign abs_im = sample_imag_i[N-1] ? N'(-sample_imag_i) : N'(sample_imag_i);

  always_comb begin
    hue0 = (hue_angle_i >= 9'd360) ? {1'b0, hue_angle_i} - 10'd360 : {1'b0, hue_angle_i};
    hue1 = hue0;
    if (sat_in_i[15]) begin
      hue1 = hue0 + 10'd180;
      if (hue1 >= 10'd360) begin
        hue1 = hue1 - 10'd360;
      end
    end
    priority if (hue1 < 10'd60)  sec = 3'd0;
    else if (hue1 < 10'd120)     sec = 3'd1;
    else if (hue1 < 10'd180)     sec = 3'd2;
    else if (hue1 < 10'd240)     sec = 3'd3;
    else if (hue1 < 10'd300)     sec = 3'd4;
    else                         sec = 3'd5;
    frac_w       = hue1 - 10'(sec) * 10'd60;
    side_in.mask = mask_code_i;
    side_in.sec  = sec;
    side_in.frac = frac_w[5:0];
    side_in.sat  = sat_in_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_re_q   <= (2*N)'(abs_re) * (2*N)'(abs_re);
      sq_im_q   <= (2*N)'(abs_im) * (2*N)'(abs_im);
      side_q[0] <= side_in;
      for (int k = 1; k < LAT - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sum (fits 2N bits), then root
  // --------------------------------------------------------------------------
  logic [2*N-1:0] sum_q;
  logic [N-1:0]   mag;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_re_q + sq_im_q;
    end
  end

  wlhc_isqrt #(.N(N)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (mag)
  );

  // --------------------------------------------------------------------------
  // Level and saturation setup for the dividers
  // --------------------------------------------------------------------------
  side_t                side_c;
  logic [MW-1:0]        mag_x, lo_x, hi_x;
  logic [15:0]          mag_cl, lvl_diff;
  logic [DIV_NUM_W-1:0] lvl_num, sat_num;
  logic [DIV_DEN_W-1:0] lvl_den, sat_den;
  logic signed [16:0]   s_ext, s_abs, s_den;
  logic signed [17:0]   s_num;
  logic [DIV_NUM_W-1:0] s_n255;
  fix_t                 fix_c;
  fix_t                 fix_q [DIV_STAGES];

  assign side_c = side_q[N+1];
  assign mag_x  = MW'(mag);
  assign lo_x   = MW'(win_lo_q);
  assign hi_x   = MW'(win_hi_q);

  always_comb begin
    fix_c    = '0;
    lvl_num  = '0;
    lvl_den  = 16'd1;
    mag_cl   = win_lo_q;
    lvl_diff = '0;
    if (win_lo_q == win_hi_q) begin
      fix_c.lvl_use = 1'b1;
      priority if (mag_x < lo_x) fix_c.lvl = 8'd0;
      else if (mag_x > hi_x)     fix_c.lvl = 8'd255;
      else                       fix_c.lvl = 8'd127;
    end else if (win_hi_q > win_lo_q) begin
      priority if (mag_x < lo_x) mag_cl = win_lo_q;
      else if (mag_x > hi_x)     mag_cl = win_hi_q;
      else                       mag_cl = mag_x[15:0];
      lvl_diff = mag_cl - win_lo_q;
      lvl_num  = {lvl_diff, 8'd0} - DIV_NUM_W'(lvl_diff);
      lvl_den  = win_hi_q - win_lo_q;
    end else begin
      fix_c.lvl_use = 1'b1;
      fix_c.lvl     = 8'd0;
    end

    // saturation: |sat| scaled into the window, clamped to 0..255
    s_ext   = {side_c.sat[15], side_c.sat};
    s_abs   = side_c.sat[15] ? -s_ext : s_ext;
    s_num   = {1'b0, s_abs} - {{2{sat_lo_q[15]}}, sat_lo_q};
    s_den   = {sat_hi_q[15], sat_hi_q} - {sat_lo_q[15], sat_lo_q};
    s_n255  = {s_num[15:0], 8'd0} - DIV_NUM_W'(s_num[16:0]);
    sat_num = '0;
    sat_den = 16'd1;
    if ((sat_hi_q > sat_lo_q) && (s_num > 18'sd0)) begin
      if ({s_num[16:0], 8'd0} - 25'(s_num[16:0]) >= {1'b0, s_den[15:0], 8'd0}) begin
        fix_c.sat_use = 1'b1;
        fix_c.satv    = 8'd255;
      end else begin
        sat_num = s_n255;
        sat_den = s_den[15:0];
      end
    end else begin
      fix_c.sat_use = 1'b1;
      fix_c.satv    = 8'd0;
    end
  end

  logic [DIV_QUO_W-1:0] lvl_quo, sat_quo;

  wlhc_div u_div_lvl (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (lvl_num),
    .den_i (lvl_den),
    .quo_o (lvl_quo)
  );

  wlhc_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sat_num),
    .den_i (sat_den),
    .quo_o (sat_quo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fix_q[0] <= fix_c;
      for (int k = 1; k < DIV_STAGES; k++) begin
        fix_q[k] <= fix_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // HSV to RGB: v = hold, s = sat
  // --------------------------------------------------------------------------
  logic [7:0]  hold_q, sat_q;
  logic [7:0]  v_e_q, s_e_q, v_f_q, s_f_q, v_g_q, s_g_q;
  logic [15:0] x_q;
  logic [13:0] w1_q, w2_q;
  logic [16:0] y_q, y_g_q;
  logic [22:0] zq_q, zt_q, zq_g_q, zt_g_q;
  logic [7:0]  pe_q, qe_q, te_q;
  logic [32:0] prod_p;
  logic [38:0] prod_q, prod_t;

  assign prod_p = 33'(y_q) * 33'(RECIP_510);
  assign prod_q = 39'(zq_q) * 39'(RECIP_30600);
  assign prod_t = 39'(zt_q) * 39'(RECIP_30600);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // select
      hold_q <= fix_q[DIV_STAGES-1].lvl_use ? fix_q[DIV_STAGES-1].lvl : lvl_quo;
      sat_q  <= fix_q[DIV_STAGES-1].sat_use ? fix_q[DIV_STAGES-1].satv : sat_quo;
      // products
      x_q   <= 16'(hold_q) * 16'(8'd255 - sat_q);
      w1_q  <= 14'(sat_q) * 14'(side_q[N+10].frac);
      w2_q  <= 14'(sat_q) * 14'(6'd60 - side_q[N+10].frac);
      v_e_q <= hold_q;
      s_e_q <= sat_q;
      // numerators
      y_q   <= {x_q, 1'b0} + 17'd255;
      zq_q  <= {23'(v_e_q) * 23'(14'd15300 - w1_q)} * 23'd2 + 23'd15300;
      zt_q  <= {23'(v_e_q) * 23'(14'd15300 - w2_q)} * 23'd2 + 23'd15300;
      v_f_q <= v_e_q;
      s_f_q <= s_e_q;
      // estimates, low by at most one
      pe_q   <= prod_p[RECIP_510_SH +: 8];
      qe_q   <= prod_q[RECIP_30600_SH +: 8];
      te_q   <= prod_t[RECIP_30600_SH +: 8];
      y_g_q  <= y_q;
      zq_g_q <= zq_q;
      zt_g_q <= zt_q;
      v_g_q  <= v_f_q;
      s_g_q  <= s_f_q;
    end
  end

  // correction and channel select
  side_t       side_o;
  logic [16:0] rp;
  logic [22:0] rq, rt;
  logic [7:0]  p_c, q_c, t_c;
  logic [7:0]  r_d, g_d, b_d;

  assign side_o = side_q[N+13];

  always_comb begin
    rp  = y_g_q - 17'(pe_q) * 17'd510;
    rq  = zq_g_q - 23'(qe_q) * 23'd30600;
    rt  = zt_g_q - 23'(te_q) * 23'd30600;
    p_c = (rp >= 17'd510)   ? pe_q + 8'd1 : pe_q;
    q_c = (rq >= 23'd30600) ? qe_q + 8'd1 : qe_q;
    t_c = (rt >= 23'd30600) ? te_q + 8'd1 : te_q;

    r_d = v_g_q;
    g_d = v_g_q;
    b_d = v_g_q;
    priority if (side_o.mask == MASK_HSV) begin
      if (s_g_q != 8'd0) begin
        unique case (side_o.sec)
          3'd0:    begin r_d = v_g_q; g_d = t_c;   b_d = p_c;   end
          3'd1:    begin r_d = q_c;   g_d = v_g_q; b_d = p_c;   end
          3'd2:    begin r_d = p_c;   g_d = v_g_q; b_d = t_c;   end
          3'd3:    begin r_d = p_c;   g_d = q_c;   b_d = v_g_q; end
          3'd4:    begin r_d = t_c;   g_d = p_c;   b_d = v_g_q; end
          3'd5:    begin r_d = v_g_q; g_d = p_c;   b_d = q_c;   end
          default: begin r_d = v_g_q; g_d = v_g_q; b_d = v_g_q; end
        endcase
      end
    end else if (side_o.mask == MASK_BLUE) begin
      b_d = 8'd255;
    end else if (side_o.mask == MASK_GREEN) begin
      g_d = 8'd255;
    end else if (side_o.mask == MASK_RED) begin
      r_d = 8'd255;
    end else begin
      // yellow tint
      r_d = 8'd255;
      g_d = 8'd255;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_o   <= r_d;
      green_o <= g_d;
      blue_o  <= b_d;
    end
  end

endmodule

>>> hdl/wlhc_checker.sv
module wlhc_checker import wlhc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [7:0]            red_o,
  input logic [7:0]            green_o,
  input logic [7:0]            blue_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("result changed while stalled");

  a_no_idle_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_prdata_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:16] == 16'd0)
    else $error("prdata upper bits set");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite) && (paddr == $past(paddr))
      |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("register readback mismatch");

endmodule

bind window_level_hsv_colorizer wlhc_checker u_wlhc_checker (.*);

>>> sim/tb_window_level_hsv_colorizer.sv
`timescale 1ns / 1ps

module tb_window_level_hsv_colorizer;
  import wlhc_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_rgb_t;

  // Scoreboard: owns its copy of the window registers and the queue of
  // colors still to come out of the pipeline.
  class color_scoreboard;
    logic [15:0] win_lo, win_hi, sat_lo, sat_hi;
    pixel_rgb_t pending_colors[$];
    int errors;

    function new();
      win_lo = WIN_LO_RST;
      win_hi = WIN_HI_RST;
      sat_lo = SAT_LO_RST;
      sat_hi = SAT_HI_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_WIN_LO: win_lo = val;
        REG_WIN_HI: win_hi = val;
        REG_SAT_LO: sat_lo = val;
        default:    sat_hi = val;
      endcase
    endfunction

    function logic [31:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r[31:0];
    endfunction

    function logic [7:0] window_level(logic [63:0] mag);
      logic [63:0] lo, hi;
      lo = 64'(win_lo);
      hi = 64'(win_hi);
      if (lo == hi) begin
        if (mag < lo) return 8'd0;
        if (mag > hi) return 8'd255;
        return 8'd127;
      end
      if (hi > lo) begin
        if (mag < lo) mag = lo;
        if (mag > hi) mag = hi;
        return 8'(((mag - lo) * 255) / (hi - lo));
      end
      return 8'd0;
    endfunction

    function pixel_rgb_t hsv_color(int h, int s, int v);
      pixel_rgb_t c;
      int f, sec, p, q, t;
      c.red = v[7:0]; c.green = v[7:0]; c.blue = v[7:0];
      if (s != 0) begin
        f = h % 60;
        sec = h / 60;
        p = (2 * v * (255 - s) + 255) / 510;
        q = (2 * v * (15300 - s * f) + 15300) / 30600;
        t = (2 * v * (15300 - s * (60 - f)) + 15300) / 30600;
        case (sec)
          0: begin c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0]; end
          1: begin c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0]; end
          2: begin c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0]; end
          3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0]; end
          4: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0]; end
          default: begin c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0]; end
        endcase
      end
      return c;
    endfunction

    function void note_pixel(logic signed [15:0] re, logic signed [15:0] im,
                             logic [7:0] mask, logic [8:0] hue_in,
                             logic signed [15:0] sat_raw);
      longint are, aim, s, slo, shi, num, qv;
      int hue, sat;
      logic [7:0] hold;
      pixel_rgb_t c;
      are = (re < 0) ? -longint'(re) : longint'(re);
      aim = (im < 0) ? -longint'(im) : longint'(im);
      hold = window_level(64'(floor_sqrt(64'(are * are + aim * aim))));
      if (mask == MASK_HSV) begin
        hue = int'(hue_in) % 360;
        s = longint'(sat_raw);
        slo = longint'($signed(sat_lo));
        shi = longint'($signed(sat_hi));
        sat = 0;
        if (s < 0) begin
          s = -s;
          hue = (hue + 180) % 360;
        end
        if (shi > slo) begin
          num = s - slo;
          if (num > 0) begin
            qv = (num * 255) / (shi - slo);
            sat = (qv > 255) ? 255 : int'(qv);
          end
        end
        c = hsv_color(hue, sat, int'(hold));
      end else if (mask == MASK_BLUE) begin
        c.red = hold; c.green = hold; c.blue = 8'd255;
      end else if (mask == MASK_GREEN) begin
        c.red = hold; c.green = 8'd255; c.blue = hold;
      end else if (mask == MASK_RED) begin
        c.red = 8'd255; c.green = hold; c.blue = hold;
      end else begin
        c.red = 8'd255; c.green = 8'd255; c.blue = hold;
      end
      pending_colors.push_back(c);
    endfunction

    function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_rgb_t e;
      if (pending_colors.size() == 0) begin
        $error("unexpected color out: %0d %0d %0d", r, g, b);
        errors++;
        return;
      end
      e = pending_colors.pop_front();
      if (r !== e.red) begin
        $error("red: expected %0d, got %0d", e.red, r); errors++;
      end
      if (g !== e.green) begin
        $error("green: expected %0d, got %0d", e.green, g); errors++;
      end
      if (b !== e.blue) begin
        $error("blue: expected %0d, got %0d", e.blue, b); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = SAMPLE_BITS_DEF + 14;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] sample_real_i = '0, sample_imag_i = '0, sat_in_i = '0;
  logic [7:0] mask_code_i = '0;
  logic [8:0] hue_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] red_o, green_o, blue_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  color_scoreboard sb = new();
  longint cycle_count = 0;
  // Receiver hold-off request, served by the sink process.
  int sink_hold_cycles = 0;
  // Stall mode: 0 random, 1 never stall
  int sink_mode = 0;

  window_level_hsv_colorizer dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("window_level_hsv_colorizer test failed");
      $finish;
    end
  end

  // Output monitor: sample at the edge where the handshake completes.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_color(red_o, green_o, blue_o);

  // Sink: random per-item stalls, plus an occasional long hold-off.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end
      w = (sink_mode == 1) ? 0 : $urandom_range(0, 14);
      if (w > 0 && $urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Stop offering items, then wait until every expected result is out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Offer one pixel; gap drawn per item unless bursting.
  task automatic send_pixel(logic signed [15:0] re, logic signed [15:0] im,
                            logic [7:0] mask, logic [8:0] hue,
                            logic signed [15:0] sat, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0 && $urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_real_i <= re; sample_imag_i <= im; mask_code_i <= mask;
    hue_angle_i <= hue; sat_in_i <= sat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(re, im, mask, hue, sat);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_pixel(bit burst);
    logic signed [15:0] re, im, sat;
    logic [7:0] mask;
    logic [8:0] hue;
    re = 16'($urandom);
    im = 16'($urandom);
    // Half the time small magnitudes so narrow windows see the full range
    if ($urandom_range(0, 1)) begin
      re = $signed(16'($urandom_range(0, 600))) - 16'sd300;
      im = $signed(16'($urandom_range(0, 600))) - 16'sd300;
    end
    case ($urandom_range(0, 9))
      0: mask = MASK_BLUE;
      1: mask = MASK_GREEN;
      2: mask = MASK_RED;
      3: mask = 8'($urandom);
      default: mask = MASK_HSV;
    endcase
    hue = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
    sat = ($urandom_range(0, 2) == 0) ? 16'($urandom)
        : $signed(16'($urandom_range(0, 1200))) - 16'sd600;
    send_pixel(re, im, mask, hue, sat, burst);
  endtask

  initial begin
    logic [15:0] wl, wh, sl, shv;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset window, field extremes, every mask, hue wrap, sat sign
    send_pixel(16'sh8000, 16'sh8000, MASK_HSV, 9'd0, 16'sh7FFF, 0);
    send_pixel(16'sh7FFF, 16'sh7FFF, MASK_HSV, 9'd359, 16'sh8000, 0);
    send_pixel(16'sd0, 16'sd0, MASK_HSV, 9'd511, 16'sd0, 0);
    send_pixel(16'sh7FFF, 16'sh8000, MASK_HSV, 9'd360, -16'sd256, 0);
    send_pixel(16'sd3000, -16'sd4000, MASK_BLUE, 9'd90, 16'sd128, 0);
    send_pixel(-16'sd3000, 16'sd4000, MASK_GREEN, 9'd150, 16'sd200, 0);
    send_pixel(16'sd1, 16'sd1, MASK_RED, 9'd210, 16'sd256, 0);
    send_pixel(16'sd20000, 16'sd20000, 8'd4, 9'd270, 16'sd50, 0);
    send_pixel(16'sd20000, 16'sd0, 8'd255, 9'd330, 16'sd50, 0);
    send_pixel(16'sd30000, 16'sd30000, MASK_HSV, 9'd45, 16'sd100, 0);
    drain();

    // Equal window: below, at and above the bound; empty sat window
    write_reg(REG_WIN_LO, 16'd100);
    write_reg(REG_WIN_HI, 16'd100);
    write_reg(REG_SAT_LO, 16'd256);
    write_reg(REG_SAT_HI, 16'd256);
    send_pixel(16'sd99, 16'sd0, MASK_HSV, 9'd10, 16'sd300, 0);
    send_pixel(16'sd60, 16'sd80, MASK_HSV, 9'd10, 16'sd300, 0);
    send_pixel(16'sd101, 16'sd0, MASK_BLUE, 9'd10, 16'sd300, 0);
    drain();

    // Inverted windows
    write_reg(REG_WIN_LO, 16'hFFFF);
    write_reg(REG_WIN_HI, 16'd0);
    write_reg(REG_SAT_LO, 16'h7FFF);
    write_reg(REG_SAT_HI, 16'h8000);
    send_pixel(16'sd500, 16'sd500, MASK_HSV, 9'd100, 16'sd1000, 0);
    send_pixel(16'sd500, 16'sd500, MASK_RED, 9'd100, -16'sd1000, 0);
    drain();

    // Widest signed sat window
    write_reg(REG_WIN_LO, 16'd0);
    write_reg(REG_WIN_HI, 16'd255);
    write_reg(REG_SAT_LO, 16'h8000);
    write_reg(REG_SAT_HI, 16'h7FFF);
    send_pixel(16'sd200, 16'sd10, MASK_HSV, 9'd300, 16'sh8000, 0);
    send_pixel(16'sd200, 16'sd10, MASK_HSV, 9'd300, 16'sh7FFF, 0);
    drain();

    // Random phases with fresh windows
    for (int ph = 0; ph < 8; ph++) begin
      wl = (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(0, 300));
      wh = (ph % 3 == 0) ? 16'hFFFF : 16'($urandom_range(0, 600));
      if (ph == 5) wh = wl;
      sl = 16'($urandom_range(0, 512));
      shv = (ph == 6) ? sl : 16'(sl + $urandom_range(1, 600));
      if (ph == 7) begin
        sl = 16'($urandom); shv = 16'($urandom);
      end
      write_reg(REG_WIN_LO, wl);
      write_reg(REG_WIN_HI, wh);
      write_reg(REG_SAT_LO, sl);
      write_reg(REG_SAT_HI, shv);
      sink_mode = ph % 2;
      for (int i = 0; i < 100; i++) random_pixel(ph % 4 == 3);
      if (ph == 2) begin
        // Long receiver hold-off while a burst keeps coming in
        sink_hold_cycles = 150;
        for (int i = 0; i < 60; i++) random_pixel(1);
      end
      // Sender pauses until the pipeline is empty
      idle_input();
      drain();
    end
    drain();

    if (sb.errors == 0 && sb.pending_colors.size() == 0) begin
      $display("window_level_hsv_colorizer test passed");
    end else begin
      $display("window_level_hsv_colorizer test failed");
    end
    $finish;
  end

endmodule
